### hdl/wrc_pkg.sv
package wrc_pkg;

   localparam int DATA_W   = 32;
   localparam int HALF_W   = 16;
   localparam int IDX_W    = 5;
   localparam int DIV_CNT_W = 5;

   localparam logic [IDX_W-1:0] IDX_SAT = 5'd16;

   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_FIELD_BYTES   = 32'd16;
   localparam logic [15:0] ENC_PCM           = 16'd1;
   localparam logic [15:0] ENC_FLOAT         = 16'd3;
   localparam logic [15:0] PCM_UNSIGNED_BITS = 16'd8;

   // request opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_END  = 1'b1;

   // response kinds
   localparam logic [1:0] KIND_CONSUMED = 2'd0;
   localparam logic [1:0] KIND_SAMPLE   = 2'd1;
   localparam logic [1:0] KIND_FORM_ERR = 2'd2;
   localparam logic [1:0] KIND_REPORT   = 2'd3;

   // sample types
   localparam logic [1:0] SK_NONE     = 2'd0;
   localparam logic [1:0] SK_UNSIGNED = 2'd1;
   localparam logic [1:0] SK_SIGNED   = 2'd2;
   localparam logic [1:0] SK_FLOAT    = 2'd3;

   typedef enum logic [6:0] {
      PH_RIFF = 7'b000_0001,
      PH_HDR  = 7'b000_0010,
      PH_FMT  = 7'b000_0100,
      PH_DATA = 7'b000_1000,
      PH_SKIP = 7'b001_0000,
      PH_PAD  = 7'b010_0000,
      PH_HALT = 7'b100_0000
   } phase_type;

   typedef enum logic [1:0] {
      ST_READY  = 2'b01,
      ST_DIVIDE = 2'b10
   } top_state_type;

   // per-byte transaction result
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] sample_byte;
      logic       chunk_first;
   } byte_res_type;

   // end-of-file report, minus the sample count
   typedef struct packed {
      logic [15:0] encoding;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] bits;
      logic [15:0] align;
      logic [1:0]  sample_kind;
      logic        track_ok;
      logic [31:0] data_length;
   } report_type;

endpackage

### hdl/wrc_div.sv
module wrc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [wrc_pkg::DATA_W-1:0]  dividend,
   input  logic [wrc_pkg::HALF_W-1:0]  divisor,
   output logic                        done,
   output logic [wrc_pkg::DATA_W-1:0]  quotient
);

   localparam logic [wrc_pkg::DIV_CNT_W-1:0] LAST_STEP = wrc_pkg::DIV_CNT_W'(wrc_pkg::DATA_W - 1);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [wrc_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [wrc_pkg::DATA_W-1:0]     quo_ff, quo_in;
   logic [wrc_pkg::HALF_W-1:0]     rem_ff, rem_in;
   logic [wrc_pkg::HALF_W-1:0]     div_ff, div_in;
   logic [wrc_pkg::HALF_W:0]       shifted;
   logic [wrc_pkg::HALF_W:0]       diff;
   logic                           ge;

   // shared compare/subtract: one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[wrc_pkg::DATA_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = (shifted >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[wrc_pkg::DATA_W-2:0], ge};
         rem_in = ge ? diff[wrc_pkg::HALF_W-1:0] : shifted[wrc_pkg::HALF_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("divider busy and done together");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && div_ff != '0 && cnt_ff != '0) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

endmodule

### hdl/wrc_parse.sv
module wrc_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 clear,
   input  logic [7:0]           byte_value,
   output wrc_pkg::byte_res_type byte_res,
   output wrc_pkg::report_type   report
);

   wrc_pkg::phase_type          phase_ff, phase_in;
   logic [wrc_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [31:0]                 tag_ff, tag_in;
   logic [31:0]                 size_ff, size_in;
   logic [31:0]                 left_ff, left_in;
   logic                        pad_ff, pad_in;
   logic [15:0]                 enc_ff, enc_in;
   logic [15:0]                 chan_ff, chan_in;
   logic [31:0]                 rate_ff, rate_in;
   logic [15:0]                 align_ff, align_in;
   logic [15:0]                 bits_ff, bits_in;
   logic                        fmt_seen_ff, fmt_seen_in;
   logic                        data_seen_ff, data_seen_in;
   logic [31:0]                 dlen_ff, dlen_in;

   logic [31:0]                 tag_new;
   logic [31:0]                 size_new;
   logic [wrc_pkg::IDX_W-1:0]   idx_inc;
   logic [1:0]                  skind;

   assign tag_new  = {tag_ff[23:0], byte_value};
   assign size_new = {byte_value, size_ff[31:8]};
   assign idx_inc  = (idx_ff == wrc_pkg::IDX_SAT) ? idx_ff : idx_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      tag_in       = tag_ff;
      size_in      = size_ff;
      left_in      = left_ff;
      pad_in       = pad_ff;
      enc_in       = enc_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      align_in     = align_ff;
      bits_in      = bits_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      dlen_in      = dlen_ff;
      byte_res     = '0;

      if (clear) begin
         phase_in     = wrc_pkg::PH_RIFF;
         idx_in       = '0;
         tag_in       = '0;
         size_in      = '0;
         left_in      = '0;
         pad_in       = 1'b0;
         enc_in       = '0;
         chan_in      = '0;
         rate_in      = '0;
         align_in     = '0;
         bits_in      = '0;
         fmt_seen_in  = 1'b0;
         data_seen_in = 1'b0;
         dlen_in      = '0;
      end else if (step) begin
         case (phase_ff)
            wrc_pkg::PH_RIFF: begin
               if (idx_ff >= wrc_pkg::IDX_W'(8)) tag_in = tag_new;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == wrc_pkg::IDX_W'(11)) begin
                  idx_in = '0;
                  if (tag_new != wrc_pkg::TAG_WAVE) begin
                     phase_in      = wrc_pkg::PH_HALT;
                     byte_res.kind = wrc_pkg::KIND_FORM_ERR;
                  end else begin
                     phase_in = wrc_pkg::PH_HDR;
                  end
               end
            end
            wrc_pkg::PH_HDR: begin
               if (idx_ff < wrc_pkg::IDX_W'(4)) tag_in = tag_new;
               else size_in = size_new;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == wrc_pkg::IDX_W'(7)) begin
                  idx_in  = '0;
                  left_in = size_new;
                  pad_in  = size_new[0];
                  if (tag_ff == wrc_pkg::TAG_FMT) begin
                     enc_in      = '0;
                     chan_in     = '0;
                     rate_in     = '0;
                     align_in    = '0;
                     bits_in     = '0;
                     fmt_seen_in = (size_new >= wrc_pkg::FMT_FIELD_BYTES);
                     phase_in    = wrc_pkg::PH_FMT;
                  end else if (tag_ff == wrc_pkg::TAG_DATA) begin
                     data_seen_in = 1'b1;
                     dlen_in      = size_new;
                     phase_in     = wrc_pkg::PH_DATA;
                  end else begin
                     phase_in = wrc_pkg::PH_SKIP;
                  end
                  // empty body: straight to the next header (even size, no pad)
                  if (size_new == '0) phase_in = wrc_pkg::PH_HDR;
               end
            end
            wrc_pkg::PH_FMT, wrc_pkg::PH_DATA, wrc_pkg::PH_SKIP: begin
               if (phase_ff == wrc_pkg::PH_FMT) begin
                  case (idx_ff)
                     5'd0:    enc_in[7:0]     = byte_value;
                     5'd1:    enc_in[15:8]    = byte_value;
                     5'd2:    chan_in[7:0]    = byte_value;
                     5'd3:    chan_in[15:8]   = byte_value;
                     5'd4:    rate_in[7:0]    = byte_value;
                     5'd5:    rate_in[15:8]   = byte_value;
                     5'd6:    rate_in[23:16]  = byte_value;
                     5'd7:    rate_in[31:24]  = byte_value;
                     5'd12:   align_in[7:0]   = byte_value;
                     5'd13:   align_in[15:8]  = byte_value;
                     5'd14:   bits_in[7:0]    = byte_value;
                     5'd15:   bits_in[15:8]   = byte_value;
                     default: ;
                  endcase
               end else if (phase_ff == wrc_pkg::PH_DATA) begin
                  byte_res.kind        = wrc_pkg::KIND_SAMPLE;
                  byte_res.sample_byte = byte_value;
                  byte_res.chunk_first = (idx_ff == '0);
               end
               idx_in  = idx_inc;
               left_in = left_ff - 1'b1;
               if (left_ff == 32'd1) begin
                  idx_in   = '0;
                  phase_in = pad_ff ? wrc_pkg::PH_PAD : wrc_pkg::PH_HDR;
               end
            end
            wrc_pkg::PH_PAD: begin
               pad_in   = 1'b0;
               idx_in   = '0;
               phase_in = wrc_pkg::PH_HDR;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wrc_pkg::PH_RIFF;
         idx_ff       <= '0;
         tag_ff       <= '0;
         size_ff      <= '0;
         left_ff      <= '0;
         pad_ff       <= 1'b0;
         enc_ff       <= '0;
         chan_ff      <= '0;
         rate_ff      <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         dlen_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         tag_ff       <= tag_in;
         size_ff      <= size_in;
         left_ff      <= left_in;
         pad_ff       <= pad_in;
         enc_ff       <= enc_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         align_ff     <= align_in;
         bits_ff      <= bits_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         dlen_ff      <= dlen_in;
      end
   end

   always_comb begin
      if (enc_ff == wrc_pkg::ENC_PCM) begin
         skind = (bits_ff == wrc_pkg::PCM_UNSIGNED_BITS) ? wrc_pkg::SK_UNSIGNED
                                                         : wrc_pkg::SK_SIGNED;
      end else if (enc_ff == wrc_pkg::ENC_FLOAT) begin
         skind = wrc_pkg::SK_FLOAT;
      end else begin
         skind = wrc_pkg::SK_NONE;
      end
   end

   // HALT is entered only on a bad form type, so it stands for the error flag
   always_comb begin
      report.encoding    = enc_ff;
      report.channels    = chan_ff;
      report.rate        = rate_ff;
      report.bits        = bits_ff;
      report.align       = align_ff;
      report.sample_kind = skind;
      report.track_ok    = (phase_ff != wrc_pkg::PH_RIFF) && (phase_ff != wrc_pkg::PH_HALT) &&
                           fmt_seen_ff && data_seen_ff && (skind != wrc_pkg::SK_NONE) &&
                           (align_ff != '0);
      report.data_length = dlen_ff;
   end

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wrc_pkg::PH_FMT || phase_ff == wrc_pkg::PH_DATA ||
       phase_ff == wrc_pkg::PH_SKIP) |-> (left_ff != '0))
      else $error("chunk body phase with nothing left");

   a_pad_flag: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wrc_pkg::PH_PAD) |-> pad_ff)
      else $error("pad phase without pending pad");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wrc_pkg::PH_HALT && !clear) |=> (phase_ff == wrc_pkg::PH_HALT))
      else $error("left form error state without end of file");

endmodule

### hdl/wav_riff_chunk_parser.sv
// Channel  | Direction | Handshake           | Payload
// req_*    | in        | req_valid/req_stall | opcode, byte_value
// rsp_*    | out       | rsp_valid/rsp_stall | kind, sample_byte, chunk_first, report fields
//
// A file byte's response is registered and shows the cycle after the byte is accepted.
// The end-of-file transaction stalls requests until its report: accept, 32 steps of
// the shared restoring divider (one quotient bit per cycle), done register, report valid.
// req_stall is high during the division and while a response waits on rsp_stall.
// Synchronous active-high reset returns the parser to the RIFF header phase;
// the end-of-file transaction also clears the parser as its report fields are captured.
module wav_riff_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_byte_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_sample_byte,
   output logic        rsp_chunk_first,
   output logic [15:0] rsp_encoding,
   output logic [15:0] rsp_channel_count,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_sample_bits,
   output logic [15:0] rsp_frame_bytes,
   output logic [1:0]  rsp_sample_kind,
   output logic [31:0] rsp_sample_count,
   output logic        rsp_track_valid
);

   wrc_pkg::top_state_type state_ff, state_in;
   logic                   valid_ff, valid_in;

   // response payload registers
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  sbyte_ff, sbyte_in;
   logic        first_ff, first_in;
   logic [15:0] enc_ff, enc_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] align_ff, align_in;
   logic [1:0]  skind_ff, skind_in;
   logic [31:0] count_ff, count_in;
   logic        ok_ff, ok_in;

   logic                  req_take;
   logic                  byte_take;
   logic                  end_take;
   wrc_pkg::byte_res_type byte_res;
   wrc_pkg::report_type   report;
   logic                  div_done;
   logic [31:0]           div_quo;

   // accept only in the ready state, with the output register free or emptying this cycle
   assign req_stall = (state_ff != wrc_pkg::ST_READY) || (valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign byte_take = req_take && (req_opcode == wrc_pkg::OP_BYTE);
   assign end_take  = req_take && (req_opcode == wrc_pkg::OP_END);

   wrc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (byte_take),
      .clear      (end_take),
      .byte_value (req_byte_value),
      .byte_res   (byte_res),
      .report     (report)
   );

   // sample count = last data length / block align
   wrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (end_take),
      .dividend (report.data_length),
      .divisor  (report.align),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      sbyte_in = sbyte_ff;
      first_in = first_ff;
      enc_in   = enc_ff;
      chan_in  = chan_ff;
      rate_in  = rate_ff;
      bits_in  = bits_ff;
      align_in = align_ff;
      skind_in = skind_ff;
      count_in = count_ff;
      ok_in    = ok_ff;

      if (valid_ff && !rsp_stall) valid_in = 1'b0;

      if (byte_take) begin
         valid_in = 1'b1;
         kind_in  = byte_res.kind;
         sbyte_in = byte_res.sample_byte;
         first_in = byte_res.chunk_first;
         enc_in   = '0;
         chan_in  = '0;
         rate_in  = '0;
         bits_in  = '0;
         align_in = '0;
         skind_in = wrc_pkg::SK_NONE;
         count_in = '0;
         ok_in    = 1'b0;
      end else if (end_take) begin
         // report fields load now; the count follows when the divider finishes
         state_in = wrc_pkg::ST_DIVIDE;
         valid_in = 1'b0;
         kind_in  = wrc_pkg::KIND_REPORT;
         sbyte_in = '0;
         first_in = 1'b0;
         enc_in   = report.encoding;
         chan_in  = report.channels;
         rate_in  = report.rate;
         bits_in  = report.bits;
         align_in = report.align;
         skind_in = report.sample_kind;
         ok_in    = report.track_ok;
      end

      if (div_done) begin
         state_in = wrc_pkg::ST_READY;
         valid_in = 1'b1;
         count_in = (align_ff == '0) ? '0 : div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrc_pkg::ST_READY;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      kind_ff  <= kind_in;
      sbyte_ff <= sbyte_in;
      first_ff <= first_in;
      enc_ff   <= enc_in;
      chan_ff  <= chan_in;
      rate_ff  <= rate_in;
      bits_ff  <= bits_in;
      align_ff <= align_in;
      skind_ff <= skind_in;
      count_ff <= count_in;
      ok_ff    <= ok_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_sample_byte   = sbyte_ff;
   assign rsp_chunk_first   = first_ff;
   assign rsp_encoding      = enc_ff;
   assign rsp_channel_count = chan_ff;
   assign rsp_sample_rate   = rate_ff;
   assign rsp_sample_bits   = bits_ff;
   assign rsp_frame_bytes   = align_ff;
   assign rsp_sample_kind   = skind_ff;
   assign rsp_sample_count  = count_ff;
   assign rsp_track_valid   = ok_ff;

   a_no_valid_while_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wrc_pkg::ST_DIVIDE) |-> !valid_ff)
      else $error("response shown during division");

   a_end_starts_div: assert property (@(posedge clock) disable iff (reset)
      end_take |=> (state_ff == wrc_pkg::ST_DIVIDE))
      else $error("end of file did not start the division");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == wrc_pkg::ST_DIVIDE))
      else $error("divider result outside division state");

   a_report_after_div: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wrc_pkg::ST_DIVIDE) && div_done) |=>
      (valid_ff && kind_ff == wrc_pkg::KIND_REPORT))
      else $error("division finished without a report");

endmodule
